@@ hdl/fsi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsi_pkg;

    // Fixed widths of the request and response fields.
    localparam int REQ_TYPE_W = 2;
    localparam int FACT_W     = 16;
    localparam int SLOT_W     = 6;
    localparam int SIZE_W     = 7;

    // Request type codes. Code 3 is a no-op that still reports membership.
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;

    // One request as it travels on the input channel.
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [FACT_W-1:0]     fact;
        logic [SLOT_W-1:0]     slot;
    } req_t;

    // One response as it travels on the output channel.
    typedef struct packed {
        logic              was_present;
        logic              dropped_full;
        logic [SIZE_W-1:0] set_size;
        logic [FACT_W-1:0] read_fact;
    } rsp_t;

    // Commands broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_APPLY
    } state_t;

endpackage

`default_nettype wire

@@ hdl/fsi_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fsi_req_if import fsi_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/fsi_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fsi_rsp_if import fsi_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/fsi_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsi_cell import fsi_pkg::*; #(
    parameter int IDX       = 0,
    parameter int FACT_BITS = 16,
    parameter int IW        = 6,
    parameter int CW        = 7,
    parameter int PW        = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctl_t            ctl,
    input  wire logic [FACT_BITS-1:0] cmp_key,
    input  wire logic [FACT_BITS-1:0] wr_key,
    input  wire logic [SLOT_W-1:0]    slot,
    input  wire logic [CW-1:0]        count,
    input  wire logic [IW-1:0]        where,
    input  wire logic [FACT_BITS-1:0] nbr_val,
    output logic      [FACT_BITS-1:0] val,
    output logic                      hit,
    output logic      [FACT_BITS-1:0] rd
);

    logic [FACT_BITS-1:0] val_reg;
    logic [FACT_BITS-1:0] val_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [FACT_BITS-1:0] rd_reg;
    logic [FACT_BITS-1:0] rd_next;
    logic                 in_use;
    logic                 pick;

    // The slot holds a live entry only while it sits below the count.
    assign in_use = count > CW'(IDX);
    assign pick   = in_use && (PW'(slot) == PW'(IDX));

    // Compare against the incoming fact and latch this slot's read data.
    always_comb
    begin
        hit_next = hit_reg;
        rd_next  = rd_reg;
        if (ctl.cmp_en)
        begin
            hit_next = in_use && (val_reg == cmp_key);
            rd_next  = pick ? val_reg : '0;
        end
    end

    // Append lands in the first free slot; removal pulls the neighbor down.
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins_en && (count == CW'(IDX)))
        begin
            val_next = wr_key;
        end
        else if (ctl.rem_en && (where <= IW'(IDX)))
        begin
            val_next = nbr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rd_reg  <= rd_next;
    end

    assign val = val_reg;
    assign hit = hit_reg;
    assign rd  = rd_reg;

endmodule

`default_nettype wire

@@ hdl/fact_set_insert_remove.sv @@
// Channel | Dir | Payload                                          | Handshake
// req     | in  | req_type, fact, slot                             | valid/ready
// rsp     | out | was_present, dropped_full, set_size, read_fact   | valid/ready
//
// Each request goes through the sequencer steps in turn: accept and compare in every slot cell,
// resolve the match position and read data through OR trees, then apply.
// A new request is accepted only once the previous one has been applied.
// Reset clears the fact count and the sequencer; slot contents stay unknown.
// The apply step waits while a previous response has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module fact_set_insert_remove import fsi_pkg::*; #(
    parameter int CAPACITY  = 64,
    parameter int FACT_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsi_req_if.sink    req,
    fsi_rsp_if.source  rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (IW > SLOT_W) ? IW : SLOT_W;

    state_t               state_reg;
    state_t               state_next;
    logic [REQ_TYPE_W-1:0] kind_reg;
    logic [REQ_TYPE_W-1:0] kind_next;
    logic [FACT_BITS-1:0] key_reg;
    logic [FACT_BITS-1:0] key_next;
    logic                 present_reg;
    logic                 present_next;
    logic [IW-1:0]        where_reg;
    logic [IW-1:0]        where_next;
    logic [FACT_BITS-1:0] rdval_reg;
    logic [FACT_BITS-1:0] rdval_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_t                 rsp_data_reg;
    rsp_t                 rsp_data_next;

    cell_ctl_t            ctl;
    logic                 fire;
    logic                 is_full;
    logic                 dropped;
    logic [FACT_BITS-1:0] cmp_key;
    logic [CAPACITY-1:0]  hits;
    logic [FACT_BITS-1:0] cell_val [CAPACITY];
    logic [FACT_BITS-1:0] cell_rd  [CAPACITY];

    assign fire    = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp.ready);
    assign is_full = count_reg == CW'(CAPACITY);
    assign cmp_key = FACT_BITS'(req.payload.fact);

    // Row of slot cells, each one handing its entry to its lower neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        fsi_cell #(
            .IDX       (i),
            .FACT_BITS (FACT_BITS),
            .IW        (IW),
            .CW        (CW),
            .PW        (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .cmp_key (cmp_key),
            .wr_key  (key_reg),
            .slot    (req.payload.slot),
            .count   (count_reg),
            .where   (where_reg),
            .nbr_val (cell_val[(i + 1 < CAPACITY) ? i + 1 : i]),
            .val     (cell_val[i]),
            .hit     (hits[i]),
            .rd      (cell_rd[i])
        );
    end

    // Turn the one-hot match into a position and merge the read data.
    always_comb
    begin
        where_next = '0;
        rdval_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            where_next = where_next | (hits[i] ? IW'(i) : '0);
            rdval_next = rdval_next | cell_rd[i];
        end
        present_next = |hits;
        if (state_reg != ST_RESOLVE)
        begin
            where_next   = where_reg;
            rdval_next   = rdval_reg;
            present_next = present_reg;
        end
    end

    // Sequencer: next state, cell commands, count and response.
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        ctl            = '0;
        req.ready      = 1'b0;
        dropped        = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req.ready  = 1'b1;
                ctl.cmp_en = req.valid;
                if (req.valid)
                begin
                    kind_next  = req.payload.req_type;
                    key_next   = cmp_key;
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (fire)
                begin
                    case (kind_reg)
                        REQ_INSERT:
                        begin
                            if (!present_reg)
                            begin
                                if (is_full)
                                begin
                                    dropped = 1'b1;
                                end
                                else
                                begin
                                    ctl.ins_en = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (present_reg)
                            begin
                                ctl.rem_en = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.was_present  = present_reg;
                    rsp_data_next.dropped_full = dropped;
                    rsp_data_next.set_size     = SIZE_W'(count_next);
                    rsp_data_next.read_fact    =
                        (kind_reg == REQ_READ) ? FACT_W'(rdval_reg) : '0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        present_reg  <= present_next;
        where_reg    <= where_next;
        rdval_reg    <= rdval_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule

`default_nettype wire

@@ hdl/fsi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsi_checker import fsi_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_payload
);

    // Only one request is in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // A refused insert means the fact was absent and the list is full.
    a_drop_absent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.dropped_full |-> !rsp_payload.was_present)
        else $error("dropped insert reports a present fact");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.dropped_full
            |-> rsp_payload.set_size == SIZE_W'(CAPACITY))
        else $error("dropped insert while list not full");

    // The reported size never exceeds the capacity.
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (CAPACITY < 128) |-> 32'(rsp_payload.set_size) <= CAPACITY)
        else $error("set size beyond capacity");

    // A stalled response holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("stalled response changed");

endmodule

bind fact_set_insert_remove fsi_checker #(
    .CAPACITY (CAPACITY)
) u_fsi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fsi_pkg::*;

    localparam int CAP         = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 50;
    localparam int SETTLE      = 12;

    // The request type code that the package leaves unnamed: a no-op.
    localparam logic [REQ_TYPE_W-1:0] REQ_NOP = 2'd3;

    // One row of the directed table. Rows marked fixed carry a typed response.
    typedef struct {
        req_t req;
        bit   fixed;
        rsp_t want;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fsi_req_if req_if ();
    fsi_rsp_if rsp_if ();

    fact_set_insert_remove #(
        .CAPACITY  (CAP),
        .FACT_BITS (FACT_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    // Shadow copy of the fact list and its count.
    logic [FACT_W-1:0] shadow_list [CAP];
    int                shadow_count;

    // Responses still owed by the block, oldest first.
    rsp_t awaited_rsp [$];
    dir_row_t dir_rows [$];

    int err_count;
    int cycle_count;
    int idle_pct;
    int stall_pct;
    int n_insert;
    int n_remove;
    int n_read;
    int n_nop;
    int n_drop;
    int n_rsp;
    int peak_size;

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        shadow_count   = 0;
        idle_pct       = 0;
        stall_pct      = 0;
    end

    // Apply one request to the shadow set and return the response it must produce.
    function automatic rsp_t next_set_response(req_t r);
        rsp_t o;
        int   where;
        int   i;
        o     = '0;
        where = shadow_count;
        for (i = 0; i < shadow_count; i++)
        begin
            if (where == shadow_count && shadow_list[i] == r.fact)
                where = i;
        end
        o.was_present = (where < shadow_count);
        case (r.req_type)
            REQ_INSERT:
            begin
                if (!o.was_present)
                begin
                    if (shadow_count >= CAP)
                        o.dropped_full = 1'b1;
                    else
                    begin
                        shadow_list[shadow_count] = r.fact;
                        shadow_count++;
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (o.was_present)
                begin
                    for (i = where; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            REQ_READ:
            begin
                if (int'(r.slot) < shadow_count)
                    o.read_fact = shadow_list[r.slot];
            end
            default:
            begin
            end
        endcase
        o.set_size = SIZE_W'(shadow_count);
        return o;
    endfunction

    function automatic void add_row(logic [REQ_TYPE_W-1:0] kind, logic [FACT_W-1:0] f,
                                    logic [SLOT_W-1:0] s, bit fixed, logic wp = 1'b0,
                                    logic [SIZE_W-1:0] sz = '0, logic [FACT_W-1:0] rf = '0);
        dir_row_t row;
        row.req.req_type       = kind;
        row.req.fact           = f;
        row.req.slot           = s;
        row.fixed              = fixed;
        row.want.was_present   = wp;
        row.want.dropped_full  = 1'b0;
        row.want.set_size      = sz;
        row.want.read_fact     = rf;
        dir_rows.push_back(row);
    endfunction

    // Fact choice: mostly members and a small pool so that hits are common.
    function automatic logic [FACT_W-1:0] pick_fact();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45 && shadow_count > 0)
            return shadow_list[$urandom_range(shadow_count - 1)];
        if (roll < 65)
            return FACT_W'($urandom_range(15));
        if (roll < 70)
            return ($urandom_range(1) != 0) ? '1 : '0;
        return FACT_W'($urandom);
    endfunction

    function automatic req_t mixed_request(int ins_pct, int rem_pct);
        req_t r;
        int   roll;
        roll   = $urandom_range(99);
        r.fact = pick_fact();
        if (shadow_count > 0 && $urandom_range(3) != 0)
            r.slot = SLOT_W'($urandom_range(shadow_count - 1));
        else
            r.slot = SLOT_W'($urandom);
        if (roll < ins_pct)
            r.req_type = REQ_INSERT;
        else if (roll < ins_pct + rem_pct)
            r.req_type = REQ_REMOVE;
        else if (roll < 97)
            r.req_type = REQ_READ;
        else
            r.req_type = REQ_NOP;
        return r;
    endfunction

    // Offer one request, wait for its acceptance and record the owed response.
    task automatic send_request(req_t r, bit fixed, rsp_t want);
        rsp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predicted = next_set_response(r);
        awaited_rsp.push_back(fixed ? want : predicted);
        case (r.req_type)
            REQ_INSERT: n_insert++;
            REQ_REMOVE: n_remove++;
            REQ_READ:   n_read++;
            default:    n_nop++;
        endcase
        if (predicted.dropped_full)
            n_drop++;
        if (shadow_count > peak_size)
            peak_size = shadow_count;
    endtask

    // Insert fresh facts until the list is full, then push against the limit.
    task automatic fill_set();
        req_t r;
        r.req_type = REQ_INSERT;
        r.slot     = SLOT_W'($urandom);
        while (shadow_count < CAP)
        begin
            r.req_type = REQ_INSERT;
            r.fact     = FACT_W'($urandom);
            r.slot     = SLOT_W'($urandom);
            send_request(r, 1'b0, '0);
        end
        repeat (3)
        begin
            r.fact = FACT_W'($urandom);
            send_request(r, 1'b0, '0);
        end
        r.fact = shadow_list[$urandom_range(CAP - 1)];
        send_request(r, 1'b0, '0);
        r.req_type = REQ_READ;
        r.slot     = SLOT_W'(CAP - 1);
        send_request(r, 1'b0, '0);
    endtask

    // Remove members in random order, mixed with occasional reads and no-ops, until the list is empty.
    task automatic drain_set();
        req_t r;
        while (shadow_count > 0)
        begin
            if ($urandom_range(4) == 0)
                r = mixed_request(0, 0);
            else
            begin
                r.req_type = REQ_REMOVE;
                r.fact     = shadow_list[$urandom_range(shadow_count - 1)];
                r.slot     = SLOT_W'($urandom);
            end
            send_request(r, 1'b0, '0);
        end
    endtask

    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Response checker, receiver stalls and the run limit.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses owed", cycle_count,
                     awaited_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                n_rsp++;
                if (awaited_rsp.size() == 0)
                begin
                    $error("response with none owed: %p", rsp_if.payload);
                    err_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_if.payload.was_present !== want.was_present)
                    begin
                        $error("was_present: expected %0d, got %0d", want.was_present,
                               rsp_if.payload.was_present);
                        err_count++;
                    end
                    if (rsp_if.payload.dropped_full !== want.dropped_full)
                    begin
                        $error("dropped_full: expected %0d, got %0d", want.dropped_full,
                               rsp_if.payload.dropped_full);
                        err_count++;
                    end
                    if (rsp_if.payload.set_size !== want.set_size)
                    begin
                        $error("set_size: expected %0d, got %0d", want.set_size,
                               rsp_if.payload.set_size);
                        err_count++;
                    end
                    if (rsp_if.payload.read_fact !== want.read_fact)
                    begin
                        $error("read_fact: expected 0x%04h, got 0x%04h", want.read_fact,
                               rsp_if.payload.read_fact);
                        err_count++;
                    end
                end
            end
            rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus: directed table, then random phases under different idling.
    initial
    begin : stimulus
        int ph;
        int k;
        int ins_pct;
        int rem_pct;

        // Empty set, then the extremes of the fact and slot fields.
        add_row(REQ_READ,   16'h0000, 6'd0,  1'b1, 1'b0, 7'd0, 16'h0000);
        add_row(REQ_REMOVE, 16'h1234, 6'd0,  1'b1, 1'b0, 7'd0, 16'h0000);
        add_row(REQ_NOP,    16'h0000, 6'd0,  1'b1, 1'b0, 7'd0, 16'h0000);
        add_row(REQ_INSERT, 16'h0000, 6'd0,  1'b1, 1'b0, 7'd1, 16'h0000);
        add_row(REQ_INSERT, 16'hFFFF, 6'd63, 1'b1, 1'b0, 7'd2, 16'h0000);
        add_row(REQ_INSERT, 16'h0000, 6'd0,  1'b1, 1'b1, 7'd2, 16'h0000);
        add_row(REQ_READ,   16'h5555, 6'd1,  1'b1, 1'b0, 7'd2, 16'hFFFF);
        add_row(REQ_READ,   16'h0000, 6'd63, 1'b1, 1'b1, 7'd2, 16'h0000);
        add_row(REQ_INSERT, 16'h8000, 6'd0,  1'b0);
        add_row(REQ_INSERT, 16'h0001, 6'd0,  1'b0);
        add_row(REQ_INSERT, 16'h2AAA, 6'd0,  1'b0);
        add_row(REQ_INSERT, 16'h5555, 6'd0,  1'b0);
        // Removal from the middle shifts the later entries down.
        add_row(REQ_REMOVE, 16'h8000, 6'd0,  1'b1, 1'b1, 7'd5, 16'h0000);
        add_row(REQ_READ,   16'h0000, 6'd2,  1'b0);
        add_row(REQ_READ,   16'hFFFF, 6'd4,  1'b0);
        add_row(REQ_REMOVE, 16'h0000, 6'd0,  1'b1, 1'b1, 7'd4, 16'h0000);
        add_row(REQ_REMOVE, 16'h5555, 6'd0,  1'b0);
        add_row(REQ_NOP,    16'hFFFF, 6'd63, 1'b1, 1'b1, 7'd3, 16'h0000);
        add_row(REQ_READ,   16'h0000, 6'd0,  1'b1, 1'b0, 7'd3, 16'hFFFF);
        add_row(REQ_READ,   16'h0000, 6'd3,  1'b1, 1'b0, 7'd3, 16'h0000);
        add_row(REQ_REMOVE, 16'hFFFF, 6'd63, 1'b0);
        add_row(REQ_REMOVE, 16'h2AAA, 6'd0,  1'b0);
        add_row(REQ_REMOVE, 16'h0001, 6'd0,  1'b1, 1'b1, 7'd0, 16'h0000);
        add_row(REQ_READ,   16'h0000, 6'd0,  1'b1, 1'b0, 7'd0, 16'h0000);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].want);
        wait_quiet();

        // No idling, sender idle, receiver stalling, then both.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 69; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            ins_pct = (ph == 2) ? 30 : 45;
            rem_pct = (ph == 2) ? 45 : 30;
            if (ph == 0 || ph == 3)
                fill_set();
            for (k = 0; k < PHASE_ITEMS; k++)
                send_request(mixed_request(ins_pct, rem_pct), 1'b0, '0);
            if (ph == 1 || ph == 3)
                drain_set();
            // Hold off until every owed response has come back.
            wait_quiet();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d inserts (%0d refused when full), %0d removes, %0d reads, %0d no-ops",
                 n_insert, n_drop, n_remove, n_read, n_nop);
        $display("%0d responses checked, peak set size %0d, %0d mismatches",
                 n_rsp, peak_size, err_count);
        if (err_count == 0 && awaited_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ fact_set_insert_remove.f @@
hdl/fsi_pkg.sv
hdl/fsi_req_if.sv
hdl/fsi_rsp_if.sv
hdl/fsi_cell.sv
hdl/fact_set_insert_remove.sv
hdl/fsi_checker.sv
dv/tb_top.sv
